// ----- design/ljpf_pkg.sv -----
// shared types, constants and latencies for the lennard-jones pair force pipeline
// depends on nothing; every module of the block but ljpf_delay imports it
package ljpf_pkg;

	localparam int MANT_W = 32;
	localparam int EXP_W = 12;

	typedef logic signed [EXP_W-1:0] exp_t;

	// mantissa normalized to [2^31, 2^32), or zero
	typedef struct packed {
		logic [MANT_W-1:0] m;
		exp_t e;
	} pf_t;

	localparam int POS_W = 32;
	localparam int DIFF_W = POS_W + 1;
	localparam int SQ_W = 2 * POS_W;
	localparam int D2_W = SQ_W + 2;
	localparam int FORCE_W = 48;
	localparam int EPS_SCALE = 24;
	localparam int E24_W = POS_W + 5;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON = CFG_IDX_W'(1);
	localparam logic [CFG_DATA_W-1:0] SIGMA_RESET = CFG_DATA_W'(65536);
	localparam logic [CFG_DATA_W-1:0] EPSILON_RESET = CFG_DATA_W'(65536);

	localparam logic [FORCE_W-1:0] FORCE_MAX_MAG = 48'h7FFF_FFFF_FFFF;
	localparam logic [FORCE_W-1:0] FORCE_MIN_MAG = 48'h8000_0000_0000;
	localparam int FIX_SAT_EXP = 17;

	localparam int NORM_LAT = 2;
	localparam int MUL_LAT = 2;
	localparam int DIV_STEPS = MANT_W + 1;
	localparam int DIV_LAT = DIV_STEPS + 1;
	localparam int SUB_LAT = 3 + NORM_LAT;
	localparam int FIX_LAT = 2;

endpackage

// ----- design/ljpf_delay.sv -----
// fixed-depth delay line for side data that rides along the pipeline
// depends on nothing
module ljpf_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] pipe_q [D];

	always_ff @(posedge clk) begin
		pipe_q[0] <= din;
		for (int i = 1; i < D; i++) begin
			pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign dout = pipe_q[D-1];

endmodule

// ----- design/ljpf_norm.sv -----
// two-stage normalizer: leading-zero count, then shift to a 32-bit mantissa
// depends on ljpf_pkg
module ljpf_norm import ljpf_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic [W-1:0] x,
	input  exp_t         e_in,
	output pf_t          y
);

	localparam int LZ_W = $clog2(W);

	logic [LZ_W-1:0] lz;
	logic [W-1:0]    x_s1;
	logic [LZ_W-1:0] lz_s1;
	exp_t            e_s1;
	logic            zero_s1;
	logic [W-1:0]    shifted;
	pf_t             y_s2;

	// highest set bit wins
	always_comb begin
		lz = '0;
		for (int i = 0; i < W; i++) begin
			if (x[i]) begin
				lz = LZ_W'(W - 1 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x;
		lz_s1 <= lz;
		e_s1 <= e_in;
		zero_s1 <= (x == '0);
	end

	assign shifted = x_s1 << lz_s1;

	always_ff @(posedge clk) begin
		if (zero_s1) begin
			y_s2 <= '0;
		end else begin
			y_s2.m <= shifted[W-1 -: MANT_W];
			y_s2.e <= e_s1 + exp_t'(W - MANT_W) - exp_t'(lz_s1);
		end
	end

	assign y = y_s2;

endmodule

// ----- design/ljpf_mul.sv -----
// two-stage multiply of normalized values, truncating to 32 mantissa bits
// depends on ljpf_pkg
module ljpf_mul import ljpf_pkg::*; (
	input  logic clk,
	input  pf_t  a,
	input  pf_t  b,
	output pf_t  y
);

	logic [2*MANT_W-1:0] prod_s1;
	exp_t                e_s1;
	logic                zero_s1;
	pf_t                 y_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= a.m * b.m;
		e_s1 <= a.e + b.e;
		zero_s1 <= (a.m == '0) || (b.m == '0);
	end

	// product of two normalized mantissas has its top bit at 63 or 62
	always_ff @(posedge clk) begin
		if (zero_s1) begin
			y_s2 <= '0;
		end else if (prod_s1[2*MANT_W-1]) begin
			y_s2.m <= prod_s1[2*MANT_W-1 -: MANT_W];
			y_s2.e <= e_s1 + exp_t'(MANT_W);
		end else begin
			y_s2.m <= prod_s1[2*MANT_W-2 -: MANT_W];
			y_s2.e <= e_s1 + exp_t'(MANT_W - 1);
		end
	end

	assign y = y_s2;

endmodule

// ----- design/ljpf_div.sv -----
// pipelined restoring divider, one quotient bit per stage, 33 bits then normalize
// depends on ljpf_pkg
module ljpf_div import ljpf_pkg::*; (
	input  logic clk,
	input  pf_t  a,
	input  pf_t  b,
	output pf_t  y
);

	logic [MANT_W-1:0] rem_s  [DIV_STEPS];
	logic [MANT_W-1:0] den_s  [DIV_STEPS];
	logic [MANT_W:0]   quo_s  [DIV_STEPS];
	exp_t              exp_s  [DIV_STEPS];
	logic              zero_s [DIV_STEPS];
	logic              ge0;
	logic [MANT_W:0]   quo;
	pf_t               y_q;

	// top quotient bit: dividend is a.m shifted up by 32
	assign ge0 = (a.m >= b.m);

	always_ff @(posedge clk) begin
		rem_s[0] <= ge0 ? (a.m - b.m) : a.m;
		den_s[0] <= b.m;
		quo_s[0] <= {{MANT_W{1'b0}}, ge0};
		exp_s[0] <= a.e - b.e - exp_t'(MANT_W);
		zero_s[0] <= (a.m == '0) || (b.m == '0);
	end

	for (genvar j = 1; j < DIV_STEPS; j++) begin : g_step
		logic [MANT_W:0] trial;
		logic            ge;

		assign trial = {rem_s[j-1], 1'b0};
		assign ge = (trial >= {1'b0, den_s[j-1]});

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? MANT_W'(trial - {1'b0, den_s[j-1]}) : trial[MANT_W-1:0];
			den_s[j] <= den_s[j-1];
			quo_s[j] <= {quo_s[j-1][MANT_W-1:0], ge};
			exp_s[j] <= exp_s[j-1];
			zero_s[j] <= zero_s[j-1];
		end
	end

	assign quo = quo_s[DIV_STEPS-1];

	// quotient lies in [2^31, 2^33)
	always_ff @(posedge clk) begin
		if (zero_s[DIV_STEPS-1]) begin
			y_q <= '0;
		end else if (quo[MANT_W]) begin
			y_q.m <= quo[MANT_W:1];
			y_q.e <= exp_s[DIV_STEPS-1] + exp_t'(1);
		end else begin
			y_q.m <= quo[MANT_W-1:0];
			y_q.e <= exp_s[DIV_STEPS-1];
		end
	end

	assign y = y_q;

endmodule

// ----- design/ljpf_sub.sv -----
// a - b of two non-negative values with 31 guard bits, sign out separately
// depends on ljpf_pkg, ljpf_norm
module ljpf_sub import ljpf_pkg::*; (
	input  logic clk,
	input  pf_t  a,
	input  pf_t  b,
	output pf_t  y,
	output logic neg
);

	localparam int GUARD = MANT_W - 1;
	localparam int ALN_W = MANT_W + GUARD;

	logic              az;
	logic              bz;
	logic              a_big;
	pf_t               big;
	pf_t               small_v;
	exp_t              diff;

	pf_t               big_s1;
	logic [MANT_W-1:0] sm_m_s1;
	logic              far_s1;
	logic [5:0]        sh_s1;
	logic              neg_s1;

	logic [ALN_W-1:0]  bm_s2;
	logic [ALN_W-1:0]  sm_s2;
	exp_t              e_s2;
	logic              neg_s2;

	logic [ALN_W-1:0]  x_s3;
	exp_t              e_s3;
	logic              neg_s3;
	logic              neg_s4;
	logic              neg_s5;

	// a zero operand becomes the small side with a zero mantissa
	always_comb begin
		az = (a.m == '0);
		bz = (b.m == '0);
		a_big = bz || (!az && ((a.e > b.e) || ((a.e == b.e) && (a.m >= b.m))));
		big = a_big ? a : b;
		small_v = a_big ? b : a;
		if (az || bz) begin
			small_v.m = '0;
		end
		diff = big.e - small_v.e;
	end

	always_ff @(posedge clk) begin
		big_s1 <= big;
		sm_m_s1 <= small_v.m;
		far_s1 <= (diff >= exp_t'(ALN_W));
		sh_s1 <= diff[5:0];
		neg_s1 <= !a_big;
	end

	always_ff @(posedge clk) begin
		bm_s2 <= {big_s1.m, {GUARD{1'b0}}};
		sm_s2 <= far_s1 ? '0 : ({sm_m_s1, {GUARD{1'b0}}} >> sh_s1);
		e_s2 <= big_s1.e - exp_t'(GUARD);
		neg_s2 <= neg_s1;
	end

	always_ff @(posedge clk) begin
		x_s3 <= bm_s2 - sm_s2;
		e_s3 <= e_s2;
		neg_s3 <= neg_s2;
		neg_s4 <= neg_s3;
		neg_s5 <= neg_s4;
	end

	ljpf_norm #(.W(ALN_W)) u_norm (
		.clk  (clk),
		.x    (x_s3),
		.e_in (e_s3),
		.y    (y)
	);

	assign neg = neg_s5;

endmodule

// ----- design/ljpf_fix.sv -----
// conversion of a force magnitude to a signed q48.0 integer with saturation
// depends on ljpf_pkg
module ljpf_fix import ljpf_pkg::*; (
	input  logic                      clk,
	input  pf_t                       f,
	input  logic                      neg,
	output logic signed [FORCE_W-1:0] field,
	output logic                      sat
);

	logic [FORCE_W-1:0]        mag;
	exp_t                      nsh;
	logic [FORCE_W-1:0]        mag_s1;
	logic                      neg_s1;
	logic                      over;
	logic [FORCE_W-1:0]        clip;
	logic signed [FORCE_W-1:0] field_s2;
	logic                      sat_s2;

	assign nsh = -f.e;

	always_comb begin
		if (f.m == '0) begin
			mag = '0;
		end else if (f.e >= exp_t'(FIX_SAT_EXP)) begin
			mag = FORCE_MIN_MAG + FORCE_W'(1);
		end else if (f.e >= exp_t'(0)) begin
			mag = FORCE_W'(f.m) << f.e[4:0];
		end else if (f.e <= exp_t'(-MANT_W)) begin
			mag = '0;
		end else begin
			mag = FORCE_W'(f.m >> nsh[4:0]);
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		neg_s1 <= neg;
	end

	always_comb begin
		if (neg_s1) begin
			over = (mag_s1 > FORCE_MIN_MAG);
			clip = over ? FORCE_MIN_MAG : mag_s1;
		end else begin
			over = (mag_s1 > FORCE_MAX_MAG);
			clip = over ? FORCE_MAX_MAG : mag_s1;
		end
	end

	always_ff @(posedge clk) begin
		field_s2 <= neg_s1 ? FORCE_W'(-clip) : clip;
		sat_s2 <= over;
	end

	assign field = field_s2;
	assign sat = sat_s2;

endmodule

// ----- design/lennard_jones_pair_force.sv -----
// lennard-jones pair force, top level: front end, float pipeline, output fixing
// depends on ljpf_pkg, ljpf_delay, ljpf_norm, ljpf_mul, ljpf_div, ljpf_sub, ljpf_fix
//
// channel   | ports                                   | transaction
// ----------+-----------------------------------------+------------------------------------
// input     | start, busy, a_x..a_z, b_x..b_z         | start high while busy low
// result    | done, force_x..force_z, coincident,     | done high for one cycle, no stall
//           | saturated                               |
// config    | cfg_wr_en, cfg_index, cfg_wdata         | cfg_wr_en high, no wait
//
// one pair enters per cycle; the latency of each result is set by the two
// 34-stage dividers (one quotient bit per stage, the last normalizing) in
// series with five two-stage multiplies, the subtract, front end and fixing
// busy is always low: the pipeline never holds an item back and the receiver
// cannot stall, so nothing is ever dropped or repeated
// reset clears the valid chain and the sigma and epsilon registers (both 1.0)
// derived sigma^2 and 24*epsilon settle after a write, via product and normalizer
module lennard_jones_pair_force import ljpf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [POS_W-1:0]   a_x,
	input  logic signed [POS_W-1:0]   a_y,
	input  logic signed [POS_W-1:0]   a_z,
	input  logic signed [POS_W-1:0]   b_x,
	input  logic signed [POS_W-1:0]   b_y,
	input  logic signed [POS_W-1:0]   b_z,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata,
	output logic                      done,
	output logic signed [FORCE_W-1:0] force_x,
	output logic signed [FORCE_W-1:0] force_y,
	output logic signed [FORCE_W-1:0] force_z,
	output logic                      coincident,
	output logic                      saturated
);

	// stage numbers along the pipeline, counted in clock edges after accept
	localparam int ST_MAG  = 2;
	localparam int ST_SUM  = 4;
	localparam int ST_RI   = ST_MAG + NORM_LAT;
	localparam int ST_D2   = ST_SUM + NORM_LAT;
	localparam int ST_Q    = ST_D2 + DIV_LAT;
	localparam int ST_Q2   = ST_Q + MUL_LAT;
	localparam int ST_U    = ST_Q2 + MUL_LAT;
	localparam int ST_G    = ST_U + MUL_LAT;
	localparam int ST_W    = ST_G + SUB_LAT;
	localparam int ST_K    = ST_W + DIV_LAT;
	localparam int ST_GF   = ST_K + MUL_LAT;
	localparam int ST_F    = ST_GF + MUL_LAT;
	localparam int ST_OUT  = ST_F + FIX_LAT;
	localparam int PF_W    = $bits(pf_t);

	// configuration registers and their derived constants
	logic [CFG_DATA_W-1:0] sigma_q;
	logic [CFG_DATA_W-1:0] epsilon_q;
	logic [SQ_W-1:0]       sig2_q;
	logic [E24_W-1:0]      eps24_q;
	pf_t                   s2;
	pf_t                   e24;

	logic                  accept;
	logic [ST_OUT-1:0]     vld_q;

	logic signed [POS_W-1:0]  a_vec [3];
	logic signed [POS_W-1:0]  b_vec [3];
	logic signed [DIFF_W-1:0] diff_s1 [3];
	logic [POS_W-1:0]         rmag_s2 [3];
	logic [2:0]               rneg_s2;
	logic                     coin_s2;
	logic [SQ_W-1:0]          sq_s3 [3];
	logic [D2_W-1:0]          sum_s4;

	pf_t  d2;
	pf_t  d2_d;
	pf_t  q;
	pf_t  q_d;
	pf_t  q2;
	pf_t  u;
	pf_t  u_d;
	pf_t  gg;
	pf_t  g2;
	pf_t  w;
	logic wneg;
	logic wneg_d;
	pf_t  k;
	pf_t  gf;
	logic [2:0] rneg_d;
	logic       coin_d;
	logic signed [FORCE_W-1:0] fld [3];
	logic [2:0]                sat_l;

	// every start is taken: the pipeline moves on each cycle
	assign busy = 1'b0;
	assign accept = start && !busy;

	// configuration writes, indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
			epsilon_q <= EPSILON_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SIGMA:   sigma_q <= cfg_wdata;
				REG_EPSILON: epsilon_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sigma^2 in q32.32 and 24*epsilon in q.16, recomputed every cycle
	always_ff @(posedge clk) begin
		sig2_q <= sigma_q * sigma_q;
		eps24_q <= E24_W'(epsilon_q) * E24_W'(EPS_SCALE);
	end

	ljpf_norm #(.W(SQ_W)) u_norm_s2 (
		.clk  (clk),
		.x    (sig2_q),
		.e_in (exp_t'(-2 * 16)),
		.y    (s2)
	);

	ljpf_norm #(.W(E24_W)) u_norm_e24 (
		.clk  (clk),
		.x    (eps24_q),
		.e_in (exp_t'(-16)),
		.y    (e24)
	);

	// valid bits travel beside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[ST_OUT-2:0], accept};
		end
	end

	assign a_vec[0] = a_x;
	assign a_vec[1] = a_y;
	assign a_vec[2] = a_z;
	assign b_vec[0] = b_x;
	assign b_vec[1] = b_y;
	assign b_vec[2] = b_z;

	// front end: difference, magnitude, squares, exact 66-bit sum
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			diff_s1[i] <= DIFF_W'(a_vec[i]) - DIFF_W'(b_vec[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rmag_s2[i] <= diff_s1[i][DIFF_W-1] ? POS_W'(-diff_s1[i]) : diff_s1[i][POS_W-1:0];
			rneg_s2[i] <= diff_s1[i][DIFF_W-1];
		end
		coin_s2 <= (diff_s1[0] == '0) && (diff_s1[1] == '0) && (diff_s1[2] == '0);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s3[i] <= rmag_s2[i] * rmag_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		sum_s4 <= D2_W'(sq_s3[0]) + D2_W'(sq_s3[1]) + D2_W'(sq_s3[2]);
	end

	// d2 as a float, q32.32 scale
	ljpf_norm #(.W(D2_W)) u_norm_d2 (
		.clk  (clk),
		.x    (sum_s4),
		.e_in (exp_t'(-2 * 16)),
		.y    (d2)
	);

	// q = sigma^2 / d2
	ljpf_div u_div_q (
		.clk (clk),
		.a   (s2),
		.b   (d2),
		.y   (q)
	);

	// u = (q*q)*q
	ljpf_mul u_mul_q2 (
		.clk (clk),
		.a   (q),
		.b   (q),
		.y   (q2)
	);

	ljpf_delay #(.W(PF_W), .D(ST_Q2 - ST_Q)) u_dly_q (
		.clk  (clk),
		.din  (q),
		.dout (q_d)
	);

	ljpf_mul u_mul_u (
		.clk (clk),
		.a   (q2),
		.b   (q_d),
		.y   (u)
	);

	// 2*u^2, doubling only bumps the exponent of a nonzero value
	ljpf_mul u_mul_uu (
		.clk (clk),
		.a   (u),
		.b   (u),
		.y   (gg)
	);

	ljpf_delay #(.W(PF_W), .D(ST_G - ST_U)) u_dly_u (
		.clk  (clk),
		.din  (u),
		.dout (u_d)
	);

	always_comb begin
		g2 = gg;
		if (gg.m != '0) begin
			g2.e = gg.e + exp_t'(1);
		end
	end

	// w = u - 2u^2, sign kept apart
	ljpf_sub u_sub (
		.clk (clk),
		.a   (u_d),
		.b   (g2),
		.y   (w),
		.neg (wneg)
	);

	ljpf_delay #(.W(PF_W), .D(ST_W - ST_D2)) u_dly_d2 (
		.clk  (clk),
		.din  (d2),
		.dout (d2_d)
	);

	// k = w / d2
	ljpf_div u_div_k (
		.clk (clk),
		.a   (w),
		.b   (d2_d),
		.y   (k)
	);

	// common scale 24*epsilon*k
	ljpf_mul u_mul_gf (
		.clk (clk),
		.a   (k),
		.b   (e24),
		.y   (gf)
	);

	ljpf_delay #(.W(1), .D(ST_F - ST_W)) u_dly_wneg (
		.clk  (clk),
		.din  (wneg),
		.dout (wneg_d)
	);

	ljpf_delay #(.W(3), .D(ST_F - ST_MAG)) u_dly_rneg (
		.clk  (clk),
		.din  (rneg_s2),
		.dout (rneg_d)
	);

	ljpf_delay #(.W(1), .D(ST_OUT - ST_MAG)) u_dly_coin (
		.clk  (clk),
		.din  (coin_s2),
		.dout (coin_d)
	);

	// per-axis lane: |r_i| as a float, scale, convert with saturation
	for (genvar i = 0; i < 3; i++) begin : g_lane
		pf_t ri;
		pf_t ri_d;
		pf_t fi;

		ljpf_norm #(.W(POS_W)) u_norm_ri (
			.clk  (clk),
			.x    (rmag_s2[i]),
			.e_in (exp_t'(-16)),
			.y    (ri)
		);

		ljpf_delay #(.W(PF_W), .D(ST_GF - ST_RI)) u_dly_ri (
			.clk  (clk),
			.din  (ri),
			.dout (ri_d)
		);

		ljpf_mul u_mul_f (
			.clk (clk),
			.a   (gf),
			.b   (ri_d),
			.y   (fi)
		);

		// direction: sign of w flipped by the sign of r_i
		ljpf_fix u_fix (
			.clk   (clk),
			.f     (fi),
			.neg   (wneg_d ^ rneg_d[i]),
			.field (fld[i]),
			.sat   (sat_l[i])
		);
	end

	// coincident pairs give a zero vector and no saturation
	assign done = vld_q[ST_OUT-1];
	assign coincident = coin_d;
	assign force_x = coin_d ? '0 : fld[0];
	assign force_y = coin_d ? '0 : fld[1];
	assign force_z = coin_d ? '0 : fld[2];
	assign saturated = !coin_d && (sat_l != '0);

endmodule

// ----- tb/ljpf_checker.sv -----
// result checker for the lennard-jones pair force block: tracks register writes,
// predicts each accepted pair and compares every result; depends on ljpf_pkg
`timescale 1ns / 1ps

module ljpf_checker import ljpf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [POS_W-1:0]   a_x,
	input  logic signed [POS_W-1:0]   a_y,
	input  logic signed [POS_W-1:0]   a_z,
	input  logic signed [POS_W-1:0]   b_x,
	input  logic signed [POS_W-1:0]   b_y,
	input  logic signed [POS_W-1:0]   b_z,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                      done,
	input  logic signed [FORCE_W-1:0] force_x,
	input  logic signed [FORCE_W-1:0] force_y,
	input  logic signed [FORCE_W-1:0] force_z,
	input  logic                      coincident,
	input  logic                      saturated,
	output int                        fail_count,
	output int                        pending,
	output int                        coincident_seen,
	output int                        saturated_seen
);

	typedef struct {
		logic [31:0] m;
		int          e;
	} fnum_t;

	typedef struct {
		logic [FORCE_W-1:0] fx;
		logic [FORCE_W-1:0] fy;
		logic [FORCE_W-1:0] fz;
		logic               coin;
		logic               sat;
	} force_t;

	logic [CFG_DATA_W-1:0] sigma_q, epsilon_q;
	force_t force_queue[$];

	function automatic fnum_t fn_norm(logic [63:0] x, int e);
		fnum_t r;
		r.m = '0;
		r.e = 0;
		if (x == 0) return r;
		while (x[63:32] != 0) begin
			x = x >> 1;
			e++;
		end
		while (!x[31]) begin
			x = x << 1;
			e--;
		end
		r.m = x[31:0];
		r.e = e;
		return r;
	endfunction

	function automatic fnum_t fn_mul(fnum_t a, fnum_t b);
		if (a.m == 0 || b.m == 0) return fn_norm(0, 0);
		return fn_norm(64'(a.m) * 64'(b.m), a.e + b.e);
	endfunction

	function automatic fnum_t fn_div(fnum_t a, fnum_t b);
		if (a.m == 0 || b.m == 0) return fn_norm(0, 0);
		return fn_norm({a.m, 32'h0} / 64'(b.m), a.e - b.e - 32);
	endfunction

	function automatic fnum_t fn_sub(fnum_t a, fnum_t b, output logic neg);
		fnum_t big, lit;
		logic [63:0] bm, sm;
		int diff;
		logic a_big;
		neg = 1'b0;
		if (b.m == 0) return a;
		if (a.m == 0) begin
			neg = 1'b1;
			return b;
		end
		a_big = (a.e > b.e) || (a.e == b.e && a.m >= b.m);
		big = a_big ? a : b;
		lit = a_big ? b : a;
		neg = !a_big;
		bm = 64'(big.m) << 31;
		sm = 64'(lit.m) << 31;
		diff = big.e - lit.e;
		sm = (diff >= 63) ? 64'h0 : (sm >> diff);
		return fn_norm(bm - sm, big.e - 31);
	endfunction

	// magnitude to a signed Q48.0 integer with clipping
	function automatic logic [FORCE_W-1:0] fn_fix(fnum_t g, logic neg, inout logic sat);
		logic [63:0] mag;
		if (g.m == 0) return '0;
		if (g.e >= 17) mag = 64'(FORCE_MIN_MAG) + 1;
		else if (g.e >= 0) mag = 64'(g.m) << g.e;
		else if (g.e <= -32) mag = 0;
		else mag = 64'(g.m) >> (-g.e);
		if (neg) begin
			if (mag > 64'(FORCE_MIN_MAG)) begin
				mag = 64'(FORCE_MIN_MAG);
				sat = 1'b1;
			end
			return FORCE_W'(64'h0 - mag);
		end
		if (mag > 64'(FORCE_MAX_MAG)) begin
			mag = 64'(FORCE_MAX_MAG);
			sat = 1'b1;
		end
		return FORCE_W'(mag);
	endfunction

	function automatic force_t pair_force(logic signed [31:0] pa[3], logic signed [31:0] pb[3]);
		force_t f;
		longint rd[3];
		logic [63:0] rmag[3];
		logic [65:0] dsq;
		fnum_t d2, s2, q, u, uu, w, k, g, e24, fi;
		logic wneg, sat;
		logic [FORCE_W-1:0] comp[3];
		dsq = '0;
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rd[i] = longint'(pa[i]) - longint'(pb[i]);
			rmag[i] = (rd[i] < 0) ? 64'(-rd[i]) : 64'(rd[i]);
			dsq += 66'(rmag[i] * rmag[i]);
		end
		f = '{fx: '0, fy: '0, fz: '0, coin: 1'b0, sat: 1'b0};
		if (dsq == 0) begin
			f.coin = 1'b1;
			return f;
		end
		if (dsq[65:64] != 0) d2 = fn_norm(dsq[65:2], -30);
		else d2 = fn_norm(dsq[63:0], -32);
		s2 = fn_norm(64'(sigma_q) * 64'(sigma_q), -32);
		q = fn_div(s2, d2);
		u = fn_mul(fn_mul(q, q), q);
		uu = fn_mul(u, u);
		if (uu.m != 0) uu.e += 1;
		w = fn_sub(u, uu, wneg);
		k = fn_div(w, d2);
		e24 = fn_norm(64'(EPS_SCALE) * 64'(epsilon_q), -16);
		g = fn_mul(k, e24);
		for (int i = 0; i < 3; i++) begin
			fi = fn_mul(g, fn_norm(rmag[i], -16));
			comp[i] = fn_fix(fi, wneg != (rd[i] < 0), sat);
		end
		f.fx = comp[0];
		f.fy = comp[1];
		f.fz = comp[2];
		f.sat = sat;
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
			epsilon_q <= EPSILON_RESET;
			fail_count <= 0;
			coincident_seen <= 0;
			saturated_seen <= 0;
			force_queue.delete();
		end else begin
			if (start && !busy)
				force_queue.push_back(pair_force('{a_x, a_y, a_z}, '{b_x, b_y, b_z}));
			if (done) begin
				if (force_queue.size() == 0) begin
					$error("result with no pair outstanding");
					fail_count <= fail_count + 1;
				end else begin
					automatic force_t exp_f = force_queue.pop_front();
					automatic int bad = 0;
					if (force_x !== exp_f.fx) begin
						$error("force_x expected %h actual %h", exp_f.fx, force_x);
						bad++;
					end
					if (force_y !== exp_f.fy) begin
						$error("force_y expected %h actual %h", exp_f.fy, force_y);
						bad++;
					end
					if (force_z !== exp_f.fz) begin
						$error("force_z expected %h actual %h", exp_f.fz, force_z);
						bad++;
					end
					if (coincident !== exp_f.coin) begin
						$error("coincident expected %b actual %b", exp_f.coin, coincident);
						bad++;
					end
					if (saturated !== exp_f.sat) begin
						$error("saturated expected %b actual %b", exp_f.sat, saturated);
						bad++;
					end
					fail_count <= fail_count + bad;
					coincident_seen <= coincident_seen + int'(exp_f.coin);
					saturated_seen <= saturated_seen + int'(exp_f.sat);
				end
			end
			// register writes land after this edge's pair is predicted
			if (cfg_wr_en) begin
				if (cfg_index == REG_SIGMA) sigma_q <= cfg_wdata;
				else if (cfg_index == REG_EPSILON) epsilon_q <= cfg_wdata;
			end
		end
	end

	assign pending = force_queue.size();

endmodule

// ----- tb/tb.sv -----
// testbench top for the lennard-jones pair force block: clock, reset, pair and
// register stimulus, verdict; depends on ljpf_pkg, ljpf_checker and the block
`timescale 1ns / 1ps

module tb;
	import ljpf_pkg::*;

	logic clk, arst_n, start, busy, done, coincident, saturated;
	logic signed [POS_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic signed [FORCE_W-1:0] force_x, force_y, force_z;
	int fail_count, pending, coincident_seen, saturated_seen;
	int pairs_sent;
	logic idle_on;

	lennard_jones_pair_force u_top (.*);

	ljpf_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	// one pair transaction; start stays high across back-to-back pairs
	task automatic send_pair(logic [31:0] ax, ay, az, bx, by, bz);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		a_x <= ax; a_y <= ay; a_z <= az;
		b_x <= bx; b_y <= by; b_z <= bz;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		pairs_sent++;
	endtask

	// block is idle here: every result is back before a register changes
	// the write enable stays high across back-to-back writes; the caller drops it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random pair: mostly near neighbors at a random scale, some wide, a few coincident
	task automatic random_pair;
		logic [31:0] p[3], o[3];
		int mode, sh;
		mode = $urandom_range(0, 9);
		sh = $urandom_range(0, 31);
		for (int i = 0; i < 3; i++) begin
			p[i] = $urandom;
			o[i] = $urandom >> sh;
			if ($urandom_range(0, 1)) o[i] = -o[i];
		end
		if (mode == 0) send_pair(p[0], p[1], p[2], p[0], p[1], p[2]);
		else if (mode < 3) send_pair(p[0], p[1], p[2], $urandom, $urandom, $urandom);
		else send_pair(p[0], p[1], p[2], p[0] + o[0], p[1] + o[1], p[2] + o[2]);
	endtask

	task automatic directed_pairs;
		send_pair(0, 0, 0, 0, 0, 0);                            // coincident at origin
		send_pair(32'h7FFFFFFF, 32'h80000000, 7, 32'h7FFFFFFF, 32'h80000000, 7);
		send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000);        // widest separation
		send_pair(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0);
		send_pair(1, 0, 0, 0, 0, 0);                            // one lsb apart: clips at the reset sigma and epsilon
		send_pair(0, -1, 1, 0, 0, 0);
		send_pair(32'h10000, 0, 0, 0, 0, 0);                    // at the reset sigma, where q is one
		send_pair(32'h11F5D, 0, 0, 0, 0, 0);                    // near the minimum at the reset sigma
		send_pair(0, 32'h20000, 0, 0, 0, 0);
		send_pair(0, 0, -32'h8000, 0, 0, 0);
		send_pair(32'h8000, -32'h8000, 32'h8000, 0, 0, 0);
		send_pair(32'h00030000, 32'h00040000, 0, 0, 0, 32'h00050000);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] sig_set[6], eps_set[6];
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		{a_x, a_y, a_z, b_x, b_y, b_z} = '0;
		pairs_sent = 0;
		idle_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 0 runs on the reset values of sigma and epsilon
		sig_set = '{SIGMA_RESET, 32'hFFFFFFFF, 32'h0, 32'h00018000, $urandom, 32'h1};
		eps_set = '{EPSILON_RESET, 32'hFFFFFFFF, 32'h00010000, 32'h0, $urandom, 32'h1};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph != 0) begin
				write_reg(REG_SIGMA, sig_set[ph]);
				write_reg(REG_EPSILON, eps_set[ph]);
				// indexes past the register list must be dropped
				if (ph == 3) begin
					write_reg(CFG_IDX_W'(2), $urandom);
					write_reg(CFG_IDX_W'(3), $urandom);
				end
				cfg_wr_en <= 1'b0;
				// derived sigma^2 and 24*epsilon settle during this wait
				repeat (4) @(posedge clk);
			end
			idle_on = (ph != 5);
			directed_pairs();
			repeat (290) random_pair();
			drain();
		end

		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("covered %0d pairs over 6 sigma/epsilon settings (zero and full scale included)",
			pairs_sent);
		$display("coincident results %0d, clipped results %0d", coincident_seen, saturated_seen);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/ljpf_pkg.sv
design/ljpf_delay.sv
design/ljpf_norm.sv
design/ljpf_mul.sv
design/ljpf_div.sv
design/ljpf_sub.sv
design/ljpf_fix.sv
design/lennard_jones_pair_force.sv
tb/ljpf_checker.sv
tb/tb.sv
